[src/smacof_b_matrix_builder_unit_defines.svh]
// assertion macros for the b matrix builder
// expects clk and rst in scope at the point of use, no other dependencies
`ifndef SMACOF_B_MATRIX_BUILDER_UNIT_DEFINES_SVH
`define SMACOF_B_MATRIX_BUILDER_UNIT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SMACOF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define SMACOF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/smacof_pkg.sv]
// shared types, constants and saturation helpers for the b matrix builder
// no dependencies
package smacof_pkg;

  localparam int MAX_POINTS = 32;
  localparam int PTR_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int IDX_W      = 5;
  localparam int FIX_W      = 32;
  localparam int ENTRY_W    = 48;
  localparam int PROD_W     = 2 * FIX_W;
  localparam int CFG_IDX_W  = 1;
  localparam int PC_W       = 6;

  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [FIX_W-1:0]     fix_t;
  typedef logic [ENTRY_W-1:0]   entry_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t REG_POINT_COUNT  = 1'b0;
  localparam cfg_idx_t REG_MIN_DISTANCE = 1'b1;

  localparam entry_t Q48_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};

  // saturating add of two non-negative q32.16 values
  function automatic entry_t sat_add(entry_t a, entry_t b);
    logic [ENTRY_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, Q48_MAX}) ? Q48_MAX : s[ENTRY_W-1:0];
  endfunction

  // clamp a 64-bit quotient to the positive q32.16 range
  function automatic entry_t sat_cell(logic [PROD_W-1:0] q);
    return (|q[PROD_W-1:ENTRY_W-1]) ? Q48_MAX : {1'b0, q[ENTRY_W-2:0]};
  endfunction

endpackage

[src/smacof_ifs.sv]
// valid/ready channel interfaces: point pairs in, matrix entries out, config writes
// depends on smacof_pkg

interface smacof_pair_if;
  logic                valid;
  logic                ready;
  smacof_pkg::idx_t    row_index;
  smacof_pkg::idx_t    col_index;
  smacof_pkg::fix_t    weight;
  smacof_pkg::fix_t    dissimilarity;
  smacof_pkg::fix_t    distance;
  logic                last_pair;

  modport source (output valid, row_index, col_index, weight, dissimilarity, distance,
                  last_pair, input ready);
  modport sink   (input valid, row_index, col_index, weight, dissimilarity, distance,
                  last_pair, output ready);
endinterface

interface smacof_entry_if;
  logic                valid;
  logic                ready;
  smacof_pkg::idx_t    out_row;
  smacof_pkg::idx_t    out_col;
  smacof_pkg::entry_t  entry_value;
  logic                last_result;

  modport source (output valid, out_row, out_col, entry_value, last_result, input ready);
  modport sink   (input valid, out_row, out_col, entry_value, last_result, output ready);
endinterface

interface smacof_cfg_if;
  logic                  valid;
  logic                  ready;
  smacof_pkg::cfg_idx_t  index;
  smacof_pkg::fix_t      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/smacof_b_matrix_builder_unit.sv]
// Weighted SMACOF B matrix builder. Takes one point pair per transfer on pairs and
// gives its off-diagonal entry -floor(weight*dissimilarity/distance) on entries (zero
// when distance is zero or below min_distance), saturated to signed Q32.16. The
// positive cell is added into a 32-entry accumulator memory for both indices
// (twice when the indices are equal). A pair with last_pair set is followed by
// point_count diagonal entries, clamped to 2 to 32 (points 0 up, last_result on the
// final one), after which the accumulators read as zero again. One pair is in flight
// at a time: a pair with a usable distance passes multiply, the bit-serial 64-step
// divider, saturate, output load, read-modify-write of each accumulator on the single
// accumulator port and return to idle before the next pair can be taken; a zero cell
// skips divide and saturate. A diagonal flush does a memory read, then an output load,
// per point. Output loads wait while the output register is still full. The output
// register lets the next pair be taken while an entry still waits downstream. Config
// writes are always accepted; they are meant for idle periods. Reset clears the
// accumulators at once through per-entry valid bits, so there is no clearing pass.
// depends on smacof_pkg, smacof_ifs and smacof_b_matrix_builder_unit_defines.svh
`include "smacof_b_matrix_builder_unit_defines.svh"

module smacof_b_matrix_builder_unit (
  input  logic                  clk,
  input  logic                  rst,
  smacof_pair_if.sink           pairs,
  smacof_entry_if.source        entries,
  smacof_cfg_if.sink            cfg
);

  // sequencer states
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_MUL     = 4'd1;
  localparam logic [3:0] S_DIV     = 4'd2;
  localparam logic [3:0] S_SAT     = 4'd3;
  localparam logic [3:0] S_EMIT    = 4'd4;
  localparam logic [3:0] S_RD_ROW  = 4'd5;
  localparam logic [3:0] S_UPD_ROW = 4'd6;
  localparam logic [3:0] S_RD_COL  = 4'd7;
  localparam logic [3:0] S_UPD_COL = 4'd8;
  localparam logic [3:0] S_FL_RD   = 4'd9;
  localparam logic [3:0] S_FL_EMIT = 4'd10;

  localparam int DIV_STEPS = smacof_pkg::PROD_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam logic [smacof_pkg::CNT_W-1:0] MAX_PTS_C =
    smacof_pkg::CNT_W'(smacof_pkg::MAX_POINTS);
  localparam logic [smacof_pkg::PC_W-1:0] PC_MIN = smacof_pkg::PC_W'(2);
  localparam logic [smacof_pkg::PC_W-1:0] PC_MAX =
    smacof_pkg::PC_W'(smacof_pkg::MAX_POINTS);

  logic [3:0] state;

  // config registers
  logic [smacof_pkg::PC_W-1:0] point_count;
  smacof_pkg::fix_t            min_distance;

  // captured pair
  smacof_pkg::idx_t p_row;
  smacof_pkg::idx_t p_col;
  smacof_pkg::fix_t p_w;
  smacof_pkg::fix_t p_d;
  smacof_pkg::fix_t p_dist;
  logic             p_last;

  // divider: quotient shifts in where the product shifts out
  logic [smacof_pkg::PROD_W-1:0] quo;
  smacof_pkg::fix_t              rem;
  logic [DIV_CNT_W-1:0]          div_cnt;
  logic [smacof_pkg::FIX_W:0]    rem_sh;
  logic                          rem_ge;

  smacof_pkg::entry_t cell_val;

  // flush counter, wide enough to hold the point count
  logic [smacof_pkg::CNT_W-1:0] flush_cnt;
  logic [smacof_pkg::PC_W-1:0]  pc_eff;
  logic                         flush_last;

  // accumulator memory and its per-entry valid bits
  smacof_pkg::entry_t            sums_mem [smacof_pkg::MAX_POINTS];
  logic [smacof_pkg::MAX_POINTS-1:0] sums_vld;
  logic                          mem_re;
  logic [smacof_pkg::PTR_W-1:0]  mem_raddr;
  logic                          mem_we;
  logic [smacof_pkg::PTR_W-1:0]  mem_waddr;
  smacof_pkg::entry_t            mem_wdata;
  smacof_pkg::entry_t            rd_data;
  logic                          rd_vld;
  smacof_pkg::entry_t            rd_val;

  // output register
  logic               out_valid;
  smacof_pkg::idx_t   out_row;
  smacof_pkg::idx_t   out_col;
  smacof_pkg::entry_t out_value;
  logic               out_last;
  logic               out_free;
  logic               out_load;

  logic row_in;
  logic col_in;
  logic [3:0] after_upd;

  assign pairs.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;

  assign entries.valid       = out_valid;
  assign entries.out_row     = out_row;
  assign entries.out_col     = out_col;
  assign entries.entry_value = out_value;
  assign entries.last_result = out_last;

  assign out_free = !out_valid || entries.ready;

  // indices outside the store are emitted but not accumulated
  assign row_in = ({1'b0, p_row} < MAX_PTS_C);
  assign col_in = ({1'b0, p_col} < MAX_PTS_C);
  assign after_upd = p_last ? S_FL_RD : S_IDLE;

  // clamp the point count to between 2 and the store size
  always_comb begin
    if (point_count < PC_MIN) begin
      pc_eff = PC_MIN;
    end else if (point_count > PC_MAX) begin
      pc_eff = PC_MAX;
    end else begin
      pc_eff = point_count;
    end
  end

  assign flush_last = (smacof_pkg::PC_W'(flush_cnt) + smacof_pkg::PC_W'(1) == pc_eff);

  // one restoring division step
  assign rem_sh = {rem, quo[smacof_pkg::PROD_W-1]};
  assign rem_ge = (rem_sh >= {1'b0, p_dist});

  // entry that was never written since the last clear reads as zero
  assign rd_val = rd_vld ? rd_data : '0;

  // memory port control
  always_comb begin
    mem_re    = 1'b0;
    mem_raddr = p_row[smacof_pkg::PTR_W-1:0];
    mem_we    = 1'b0;
    mem_waddr = p_row[smacof_pkg::PTR_W-1:0];
    mem_wdata = smacof_pkg::sat_add(rd_val, cell_val);
    out_load  = 1'b0;
    unique case (state)
      S_RD_ROW: begin
        mem_re = 1'b1;
      end
      S_UPD_ROW: begin
        mem_we = 1'b1;
      end
      S_RD_COL: begin
        mem_re    = 1'b1;
        mem_raddr = p_col[smacof_pkg::PTR_W-1:0];
      end
      S_UPD_COL: begin
        mem_we    = 1'b1;
        mem_waddr = p_col[smacof_pkg::PTR_W-1:0];
      end
      S_FL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = flush_cnt[smacof_pkg::PTR_W-1:0];
      end
      S_EMIT, S_FL_EMIT: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // accumulator memory, read data registered
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sums_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= sums_mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else if (mem_re) begin
      rd_vld <= sums_vld[mem_raddr];
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count  <= smacof_pkg::PC_W'(32);
      min_distance <= smacof_pkg::FIX_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        smacof_pkg::REG_POINT_COUNT:  point_count  <= cfg.data[smacof_pkg::PC_W-1:0];
        smacof_pkg::REG_MIN_DISTANCE: min_distance <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  // pair payload and datapath registers
  always_ff @(posedge clk) begin
    if (pairs.valid && pairs.ready) begin
      p_row  <= pairs.row_index;
      p_col  <= pairs.col_index;
      p_w    <= pairs.weight;
      p_d    <= pairs.dissimilarity;
      p_dist <= pairs.distance;
      p_last <= pairs.last_pair;
    end
    unique case (state)
      S_MUL: begin
        quo      <= smacof_pkg::PROD_W'(p_w) * smacof_pkg::PROD_W'(p_d);
        rem      <= '0;
        cell_val <= '0;
      end
      S_DIV: begin
        rem <= rem_ge ? smacof_pkg::FIX_W'(rem_sh - {1'b0, p_dist})
                      : rem_sh[smacof_pkg::FIX_W-1:0];
        quo <= {quo[smacof_pkg::PROD_W-2:0], rem_ge};
      end
      S_SAT: begin
        cell_val <= smacof_pkg::sat_cell(quo);
      end
      default: begin
      end
    endcase
  end

  // sequencer, valid bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      div_cnt   <= '0;
      flush_cnt <= '0;
      sums_vld  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (entries.ready) begin
        out_valid <= 1'b0;
      end
      if (mem_we) begin
        sums_vld[mem_waddr] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pairs.valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          div_cnt <= '0;
          // zero distance or below the floor gives a zero cell, no divide
          if (p_dist == '0 || p_dist < min_distance) begin
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          div_cnt <= div_cnt + DIV_CNT_W'(1);
          if (div_cnt == DIV_LAST) begin
            state <= S_SAT;
          end
        end
        S_SAT: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            if (row_in) begin
              state <= S_RD_ROW;
            end else if (col_in) begin
              state <= S_RD_COL;
            end else begin
              state <= after_upd;
            end
          end
        end
        S_RD_ROW: begin
          state <= S_UPD_ROW;
        end
        S_UPD_ROW: begin
          state <= col_in ? S_RD_COL : after_upd;
        end
        S_RD_COL: begin
          state <= S_UPD_COL;
        end
        S_UPD_COL: begin
          state <= after_upd;
        end
        S_FL_RD: begin
          state <= S_FL_EMIT;
        end
        S_FL_EMIT: begin
          if (out_free) begin
            if (flush_last) begin
              // whole store reads as zero from here on
              sums_vld  <= '0;
              flush_cnt <= '0;
              state     <= S_IDLE;
            end else begin
              flush_cnt <= flush_cnt + smacof_pkg::CNT_W'(1);
              state     <= S_FL_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output payload, loaded only when the slot is free
  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state == S_FL_EMIT) begin
        out_row   <= flush_cnt[smacof_pkg::IDX_W-1:0];
        out_col   <= flush_cnt[smacof_pkg::IDX_W-1:0];
        out_value <= rd_val;
        out_last  <= flush_last;
      end else begin
        out_row   <= p_row;
        out_col   <= p_col;
        out_value <= smacof_pkg::ENTRY_W'(0) - cell_val;
        out_last  <= 1'b0;
      end
    end
  end

  `SMACOF_ASSERT_NOW(a_no_overwrite, out_load, (!out_valid || entries.ready), "output register overwritten before transfer")
  `SMACOF_ASSERT_NEXT(a_div_done, (state == S_DIV && div_cnt == DIV_LAST), (state == S_SAT), "divider did not finish after its last step")
  `SMACOF_ASSERT_NEXT(a_flush_clears, (state == S_FL_EMIT && out_load && flush_last), (sums_vld == '0 && state == S_IDLE), "accumulators not cleared after flush")
  `SMACOF_ASSERT_NEXT(a_one_in_flight, (pairs.valid && pairs.ready), (state == S_MUL && !pairs.ready), "pair taken while another is in flight")

endmodule
